### design/mpcd_pkg.sv
package mpcd_pkg;

	localparam int DEFAULT_MAX_POINTS = 65536;

	localparam int GAIN_W  = 18;
	localparam int COORD_W = 32;
	localparam int MEAN_W  = 31;
	localparam int COUNT_W = 17;
	localparam int IDX_W   = 8;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_ROW_X  = 8'd0;
	localparam logic [IDX_W-1:0] REG_ROW_Y  = 8'd1;
	localparam logic [IDX_W-1:0] REG_ROW_Z  = 8'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET = 8'd3;

	localparam logic [GAIN_W-1:0]  ROW_X_RESET  = 18'sd0;
	localparam logic [GAIN_W-1:0]  ROW_Y_RESET  = 18'sd0;
	localparam logic [GAIN_W-1:0]  ROW_Z_RESET  = 18'sd65536;
	localparam logic [COORD_W-1:0] OFFSET_RESET = 32'sd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_Z,
		ST_SUM,
		ST_ACCUM,
		ST_DIV_LOAD,
		ST_DIV,
		ST_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;
		logic mul_x;
		logic mul_y;
		logic mul_z;
		logic add_prod;
		logic accum;
		logic div_load;
		logic div_step;
		logic res_load;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

### design/mpcd_ctrl.sv
module mpcd_ctrl
	import mpcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_MUL_X;
			ST_MUL_X:    state_d = ST_MUL_Y;
			ST_MUL_Y:    state_d = ST_MUL_Z;
			ST_MUL_Z:    state_d = ST_SUM;
			ST_SUM:      state_d = ST_ACCUM;
			ST_ACCUM:    state_d = sts.last ? ST_DIV_LOAD : ST_IDLE;
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV:      if (sts.div_done) state_d = ST_RESULT;
			ST_RESULT:   if (sts.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ctl.cap  = s_tvalid;
			end
			ST_MUL_X: ctl.mul_x = 1'b1;
			ST_MUL_Y: begin
				ctl.mul_y    = 1'b1;
				ctl.add_prod = 1'b1;
			end
			ST_MUL_Z: begin
				ctl.mul_z    = 1'b1;
				ctl.add_prod = 1'b1;
			end
			ST_SUM:      ctl.add_prod = 1'b1;
			ST_ACCUM:    ctl.accum    = 1'b1;
			ST_DIV_LOAD: ctl.div_load = 1'b1;
			ST_DIV:      ctl.div_step = !sts.div_done;
			ST_RESULT:   ctl.res_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

### design/mpcd_datapath.sv
module mpcd_datapath
	import mpcd_pkg::*;
#(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3*COORD_W-1:0] s_tdata,
	input  logic                s_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [COORD_W-1:0]  cfg_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [MEAN_W+COUNT_W-1:0] m_tdata,
	input  ctl_t                ctl,
	output sts_t                sts
);

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SW  = MEAN_W + CW;
	localparam int DCW = $clog2(SW + 1);
	localparam int PW  = GAIN_W + COORD_W;
	localparam int AW  = PW + 2;
	localparam int DW  = AW - 16;
	localparam logic [CW-1:0]  MAX_CNT = CW'(MAX_POINTS);
	localparam logic [DCW-1:0] DIV_STEPS = DCW'(SW);
	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

	// configuration
	logic signed [GAIN_W-1:0]  gx_q, gy_q, gz_q;
	logic signed [COORD_W-1:0] off_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q  <= ROW_X_RESET;
			gy_q  <= ROW_Y_RESET;
			gz_q  <= ROW_Z_RESET;
			off_q <= OFFSET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_X:  gx_q  <= cfg_data[GAIN_W-1:0];
				REG_ROW_Y:  gy_q  <= cfg_data[GAIN_W-1:0];
				REG_ROW_Z:  gz_q  <= cfg_data[GAIN_W-1:0];
				REG_OFFSET: off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// point capture
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic                      last_q;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			px_q   <= s_tdata[COORD_W-1:0];
			py_q   <= s_tdata[2*COORD_W-1:COORD_W];
			pz_q   <= s_tdata[3*COORD_W-1:2*COORD_W];
			last_q <= s_tlast;
		end
	end

	// shared multiplier, one product per cycle
	logic signed [GAIN_W-1:0]  op_g;
	logic signed [COORD_W-1:0] op_p;
	logic signed [PW-1:0]      prod_q;
	logic signed [AW-1:0]      acc_q;

	always_comb begin
		op_g = gx_q;
		op_p = px_q;
		if (ctl.mul_y) begin
			op_g = gy_q;
			op_p = py_q;
		end else if (ctl.mul_z) begin
			op_g = gz_q;
			op_p = pz_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_x || ctl.mul_y || ctl.mul_z) begin
			prod_q <= op_g * op_p;
		end
		if (ctl.mul_x) begin
			acc_q <= {{(AW-COORD_W-16){off_q[COORD_W-1]}}, off_q, 16'd0};
		end else if (ctl.add_prod) begin
			acc_q <= acc_q + {{(AW-PW){prod_q[PW-1]}}, prod_q};
		end
	end

	// floor to Q16.16 is dropping the low 16 bits
	logic signed [DW-1:0] depth;
	logic                 depth_pos;
	logic [MEAN_W-1:0]    depth_sat;

	assign depth     = acc_q[AW-1:16];
	assign depth_pos = !depth[DW-1] && (depth != '0);
	assign depth_sat = (depth[DW-2:MEAN_W] != '0) ? MEAN_MAX : depth[MEAN_W-1:0];

	// accumulators and divider
	logic [SW-1:0]  sum_q, dvd_q;
	logic [CW-1:0]  cnt_q, den_q, rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW:0]    rem_shift;
	logic [CW:0]    trial;
	logic           trial_ok;

	assign rem_shift = {rem_q, dvd_q[SW-1]};
	assign trial     = rem_shift - {1'b0, den_q};
	assign trial_ok  = !trial[CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			dcnt_q <= '0;
		end else begin
			if (ctl.accum && depth_pos && (cnt_q < MAX_CNT)) begin
				sum_q <= sum_q + {{(SW-MEAN_W){1'b0}}, depth_sat};
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.div_load) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (ctl.div_load) begin
				dcnt_q <= DIV_STEPS;
			end else if (ctl.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			dvd_q <= sum_q;
			den_q <= cnt_q;
			rem_q <= '0;
		end else if (ctl.div_step) begin
			rem_q <= trial_ok ? trial[CW-1:0] : rem_shift[CW-1:0];
			dvd_q <= {dvd_q[SW-2:0], trial_ok};
		end
	end

	// result register
	logic                 ovalid_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [COUNT_W-1:0]   pcnt_q;
	logic [CW+COUNT_W-1:0] den_ext;

	assign den_ext = {{COUNT_W{1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (ctl.res_load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			if (den_q == '0) begin
				mean_q <= '0;
			end else if (dvd_q[SW-1:MEAN_W] != '0) begin
				mean_q <= MEAN_MAX;
			end else begin
				mean_q <= dvd_q[MEAN_W-1:0];
			end
			pcnt_q <= den_ext[COUNT_W-1:0];
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {pcnt_q, mean_q};

	assign sts.last     = last_q;
	assign sts.div_done = (dcnt_q == '0);
	assign sts.out_free = !ovalid_q || m_tready;

endmodule

### design/mean_positive_camera_depth_top.sv
// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   s_tdata: point_x, point_y, point_z; s_tlast: last_point
// m_*       out  m_tvalid / m_tready   m_tdata: mean_depth, positive_count
// cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A point is done before the next is ready: one shared 18x32 multiplier
// forms the three depth products one per cycle, then a sum and an accumulate step.
// A point marked last then runs the restoring divider over the SW-bit sum
// (SW = 31 + clog2(MAX_POINTS+1), 48 by default), one quotient bit per cycle, then loads the result.
// The result sits in an output register; a new point is taken while it waits, and the
// next result stalls only if the previous one is still not taken.
// Reset is asynchronous, active low: config registers go to their reset values, sum and count accumulators clear.
module mean_positive_camera_depth_top
	import mpcd_pkg::*;
#(
	parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [3*COORD_W-1:0]      s_tdata,   // [31:0] point_x, [63:32] point_y, [95:64] point_z
	input  logic                      s_tlast,   // last_point
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [MEAN_W+COUNT_W-1:0] m_tdata,   // [30:0] mean_depth, [47:31] positive_count
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index, // 0 row x, 1 row y, 2 row z, 3 offset
	input  logic [COORD_W-1:0]        cfg_data
);

	ctl_t ctl;
	sts_t sts;

	// sequencer: one point at a time, divide only on the last point of a set
	mpcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// config registers, multiplier, accumulators, divider and output register
	mpcd_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

### tb/sv/mean_positive_camera_depth_top_tb.sv
module mean_positive_camera_depth_top_tb;
	import mpcd_pkg::*;

	// Block parameter under test.
	localparam int POINT_LIMIT = DEFAULT_MAX_POINTS;

	// Worst case for a set result: the per-point states, a divider of
	// 31 + clog2(MAX_POINTS+1) steps and the load states; doubled for slack.
	localparam int DRAIN_CYCLES = 2 * (6 + 31 + $clog2(POINT_LIMIT + 1) + 3);

	// Timeout, far above the slowest legal run: ~1300 points, with a divide
	// on each when every point closes a set, plus idle gaps, stalls,
	// settling between phases and one long output hold-off.
	localparam int CYCLE_LIMIT = 1_000_000;

	localparam int ITEMS_PER_PHASE = 300;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int PRESSURE_SETS = 24;
	localparam int MAX_PRINTED = 40;

	localparam longint DEPTH_MAX = 64'sh7FFF_FFFF;

	localparam logic [GAIN_W-1:0] GAIN_MIN = 18'h2_0000;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 18'h1_FFFF;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 18'h1_0000;
	localparam logic [GAIN_W-1:0] GAIN_LSB = 18'h0_0001;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] COORD_ONE = 32'h0001_0000;

	// How the depth row is chosen for a random phase
	typedef enum int {
		ROW_FULL,
		ROW_SMALL,
		ROW_EXTREME
	} row_style_t;

	typedef struct {
		logic [MEAN_W-1:0]  mean_depth;
		logic [COUNT_W-1:0] positive_count;
	} depth_mean_t;

	// Tracks the depth row and the running positive-depth accumulators,
	// and holds the set results still owed by the block.
	class depth_mean_scoreboard;
		longint row_x;
		longint row_y;
		longint row_z;
		longint row_offset;
		longint pos_sum;
		int unsigned pos_count;
		depth_mean_t expected_means[$];
		int unsigned mismatches;
		int unsigned points_seen;
		int unsigned means_checked;
		int unsigned reg_writes;

		function new();
			row_x = $signed(ROW_X_RESET);
			row_y = $signed(ROW_Y_RESET);
			row_z = $signed(ROW_Z_RESET);
			row_offset = $signed(OFFSET_RESET);
			pos_sum = 0;
			pos_count = 0;
		endfunction

		function void note_reg_write(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_ROW_X:  row_x = $signed(data[GAIN_W-1:0]);
				REG_ROW_Y:  row_y = $signed(data[GAIN_W-1:0]);
				REG_ROW_Z:  row_z = $signed(data[GAIN_W-1:0]);
				REG_OFFSET: row_offset = $signed(data);
				default: ;
			endcase
		endfunction

		// Depth of one accepted point; on the last point of a set the mean is owed.
		function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
		                         logic [COORD_W-1:0] pz, logic last);
			longint x;
			longint y;
			longint z;
			longint acc;
			longint depth;
			longint mean;
			depth_mean_t res;
			x = $signed(px);
			y = $signed(py);
			z = $signed(pz);
			points_seen++;
			// Q2.16 * Q16.16 products and the offset lined up at 32 fraction bits
			acc = row_x * x + row_y * y + row_z * z + row_offset * 65536;
			depth = acc >>> 16;   // floor to Q16.16
			if (depth > 0 && pos_count < POINT_LIMIT) begin
				pos_sum += (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
				pos_count++;
			end
			if (last) begin
				mean = (pos_count != 0) ? pos_sum / longint'(pos_count) : 0;
				if (mean > DEPTH_MAX)
					mean = DEPTH_MAX;
				res.mean_depth = MEAN_W'(mean);
				res.positive_count = COUNT_W'(pos_count);
				expected_means.push_back(res);
				pos_sum = 0;
				pos_count = 0;
			end
		endfunction

		task check_mean(logic [MEAN_W+COUNT_W-1:0] word);
			depth_mean_t want;
			if (expected_means.size() == 0) begin
				report_mismatch($sformatf("unexpected result: mean %0d count %0d",
				                          word[MEAN_W-1:0], word[MEAN_W+:COUNT_W]));
				return;
			end
			want = expected_means.pop_front();
			means_checked++;
			if (word[MEAN_W-1:0] !== want.mean_depth)
				report_mismatch($sformatf("set %0d mean_depth: got %0d want %0d",
				                          means_checked, word[MEAN_W-1:0], want.mean_depth));
			if (word[MEAN_W+:COUNT_W] !== want.positive_count)
				report_mismatch($sformatf("set %0d positive_count: got %0d want %0d",
				                          means_checked, word[MEAN_W+:COUNT_W],
				                          want.positive_count));
		endtask

		task check_drained();
			if (expected_means.size() != 0)
				report_mismatch($sformatf("%0d set results never arrived",
				                          expected_means.size()));
		endtask

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("mismatch: %s", what);
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [3*COORD_W-1:0] s_tdata = '0;   // [31:0] point_x, [63:32] point_y, [95:64] point_z
	logic s_tlast = 1'b0;                 // last_point
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [MEAN_W+COUNT_W-1:0] m_tdata;   // [30:0] mean_depth, [47:31] positive_count
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;

	// Idling knobs, changed per phase; hold_request starts a long output hold-off.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned cycle_count = 0;

	depth_mean_scoreboard sb = new();

	mean_positive_camera_depth_top #(
		.MAX_POINTS(POINT_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: checks each accepted result, then picks next ready.
	// A requested hold-off is counted down here while m_tready is held low.
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_mean(m_tdata);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// One point item; random gaps first, then hold it until taken.
	// Leaves valid high on return: the next call or settle() drives it again.
	task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
	                          input logic [COORD_W-1:0] pz, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pz, py, px};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_point(px, py, pz, last);
	endtask

	// Register write; cfg_valid stays up for back-to-back writes.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.note_reg_write(idx, data);
	endtask

	// Whole depth row. Gains go out with random upper bits, which the block drops.
	// Optionally a write to an index past the last register first (must be ignored).
	task automatic program_depth_row(input logic [GAIN_W-1:0] gx, input logic [GAIN_W-1:0] gy,
	                                 input logic [GAIN_W-1:0] gz, input logic [COORD_W-1:0] off,
	                                 input bit with_stray);
		logic [COORD_W-1:0] data;
		if (with_stray)
			write_reg(IDX_W'($urandom_range(int'(REG_OFFSET) + 1, (1 << IDX_W) - 1)), $urandom);
		data = $urandom;
		data[GAIN_W-1:0] = gx;
		write_reg(REG_ROW_X, data);
		data = $urandom;
		data[GAIN_W-1:0] = gy;
		write_reg(REG_ROW_Y, data);
		data = $urandom;
		data[GAIN_W-1:0] = gz;
		write_reg(REG_ROW_Z, data);
		write_reg(REG_OFFSET, off);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every owed result, then let a point still in flight finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		int v;
		case ($urandom_range(0, 9))
			5, 6: begin
				v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
				return COORD_W'(v);
			end
			7: begin
				case ($urandom_range(0, 4))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					3: return 32'd1;
					default: return '1;
				endcase
			end
			8, 9: begin
				v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
				return COORD_W'(v);
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(row_style_t style);
		int v;
		case (style)
			ROW_SMALL: begin
				v = int'($urandom_range(0, 8192)) - 4096;
				return GAIN_W'(v);
			end
			ROW_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return GAIN_MIN;
					1: return GAIN_MAX;
					2: return '0;
					3: return GAIN_LSB;
					default: return '1;
				endcase
			end
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_offset(row_style_t style);
		int v;
		case (style)
			ROW_SMALL: begin
				v = int'($urandom_range(0, 1 << 24)) - (1 << 23);
				return COORD_W'(v);
			end
			ROW_EXTREME: begin
				case ($urandom_range(0, 4))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					3: return 32'd1;
					default: return '1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Mostly short sets, some long ones, a few single points.
	function automatic int unsigned pick_set_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 1;
		else if (r < 85)
			return $urandom_range(2, 12);
		else
			return $urandom_range(13, 60);
	endfunction

	initial begin : stimulus
		int unsigned phase;
		int unsigned sent;
		int unsigned len;
		int unsigned i;
		row_style_t style;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, reset depth row (z gain 1.0, rest 0) ----
		// one positive and one negative depth -> mean 1.0, count 1
		send_point('0, '0, COORD_ONE, 1'b0);
		send_point('0, '0, -COORD_ONE, 1'b1);
		// empty set: a lone last point with zero depth
		send_point('0, '0, '0, 1'b1);
		// smallest positive depth, one LSB
		send_point('0, '0, 32'd1, 1'b1);
		// coordinate extremes; x and y gains are zero
		send_point('0, '0, COORD_MAX, 1'b0);
		send_point('0, '0, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);

		// ---- floor to Q16.16: x gain of one LSB ----
		settle();
		program_depth_row(GAIN_LSB, '0, '0, '0, 1'b0);
		send_point(32'h0000_FFFF, rand_coord(), rand_coord(), 1'b1);  // floors to zero
		send_point(COORD_ONE, rand_coord(), rand_coord(), 1'b1);      // exactly one LSB
		send_point('1, rand_coord(), rand_coord(), 1'b1);             // -1 floors negative

		// ---- all gains and offset at their maxima: per-point depth saturation ----
		settle();
		program_depth_row(GAIN_MAX, GAIN_MAX, GAIN_MAX, COORD_MAX, 1'b0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
		send_point('0, '0, '0, 1'b1);

		// ---- all at their minima ----
		settle();
		program_depth_row(GAIN_MIN, GAIN_MIN, GAIN_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		send_point('0, '0, '0, 1'b1);

		// ---- out-of-range register index must leave the row unchanged ----
		settle();
		write_reg(IDX_W'($urandom_range(int'(REG_OFFSET) + 1, (1 << IDX_W) - 1)), $urandom);
		cfg_valid <= 1'b0;
		send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);

		// ---- unit z gain again, a set of large positive depths ----
		settle();
		program_depth_row('0, '0, GAIN_ONE, '0, 1'b0);
		repeat (4) send_point($urandom, $urandom, COORD_MAX, 1'b0);
		send_point($urandom, $urandom, COORD_MAX, 1'b1);

		// ---- random phases: no idling, sender idle, receiver stall, both ----
		for (phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  style = ROW_FULL;    end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  style = ROW_SMALL;   end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; style = ROW_EXTREME; end
				default: begin
					send_idle_pct = 26;
					recv_stall_pct = 26;
					style = ROW_FULL;
				end
			endcase
			program_depth_row(pick_gain(style), pick_gain(style), pick_gain(style),
			                  pick_offset(style), 1'b1);

			// Back pressure: output held off while single-point sets keep coming,
			// so the result register fills and the input stalls.
			if (phase == 0) begin
				hold_request = HOLD_OFF_CYCLES;
				repeat (PRESSURE_SETS) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
			end

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = pick_set_len();
				for (i = 0; i < len; i++)
					send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
				sent += len;
			end

			// Leave a set open across the next row change in the middle phases.
			if (phase == 1 || phase == 2)
				repeat (3) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
		end

		settle();
		sb.check_drained();

		$display("ran %0d points, %0d set results, %0d register writes",
		         sb.points_seen, sb.means_checked, sb.reg_writes);
		$display("incl. field extremes, a stray register index and a long output hold-off");
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
